// File: design/mmfr_pkg.sv
`timescale 1ns / 1ps

package mmfr_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int PLAN_LEN    = 6;
    localparam int PIDX_W      = $clog2(PLAN_LEN + 1);

    typedef logic [PTR_W-1:0] ptr_t;

    // request codes
    localparam logic [1:0] REQ_SHORT = 2'd0;
    localparam logic [1:0] REQ_SYSEX = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // status bytes and status nibbles
    localparam logic [7:0] ST_MIN       = 8'h80;
    localparam logic [7:0] ST_RT_MIN    = 8'hF8;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_EOX       = 8'hF7;
    localparam logic [7:0] ST_TIME_CODE = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_ONE_MIN   = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
    localparam logic [3:0] KIND_PROG    = 4'hC;
    localparam logic [3:0] KIND_PRESS   = 4'hD;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_COMMIT = 2'd1,
        OP_READ   = 2'd2,
        OP_DONE   = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [23:0] short_word;
        logic [7:0]  sysex_byte;
        logic        chunk_last;
    } cmd_t;

    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        message_dropped;
        logic [31:0] bytes_pushed;
    } result_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(RING_DEPTH - 1))
            r = '0;
        else
            r = p + ptr_t'(1);
        return r;
    endfunction

endpackage

// File: design/mmfr_ram.sv
`timescale 1ns / 1ps

module mmfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/mmfr_front.sv
`timescale 1ns / 1ps

module mmfr_front import mmfr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    input  logic item_done,
    input  logic q_full,
    output logic q_push,
    output op_t  q_op
);

    op_t               plan_reg [PLAN_LEN];
    logic [PIDX_W-1:0] cnt_reg;
    logic [PIDX_W-1:0] idx_reg;
    logic              busy_reg;
    logic              open_reg;

    op_t               plan [PLAN_LEN];
    logic [PIDX_W-1:0] n;
    logic              open_next;
    logic [7:0]        status;
    logic [1:0]        len;
    logic              accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign status = cmd.short_word[7:0];

    always_comb
    begin
        len = 2'd3;
        if (status[7:4] == KIND_PROG || status[7:4] == KIND_PRESS)
            len = 2'd2;
        if (status == ST_TIME_CODE || status == ST_SONG_SEL || status == ST_UNDEF_F5)
            len = 2'd2;
        else if (status == ST_SONG_POS)
            len = 2'd3;
        else if (status >= ST_ONE_MIN && status < ST_RT_MIN)
            len = 2'd1;
    end

    // build the op list for one request; DONE always closes it
    always_comb
    begin
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            plan[i] = '{kind: OP_DONE, data: 8'h00};
        end
        n         = '0;
        open_next = open_reg;
        unique case (cmd.req_type)
            REQ_SHORT:
            begin
                if (status >= ST_RT_MIN)
                begin
                    plan[n] = '{kind: OP_PUSH, data: status};
                    n = n + PIDX_W'(1);
                    if (!open_reg)
                    begin
                        plan[n] = '{kind: OP_COMMIT, data: 8'h00};
                        n = n + PIDX_W'(1);
                    end
                end
                else if (status >= ST_MIN)
                begin
                    if (open_reg)
                    begin
                        plan[n] = '{kind: OP_COMMIT, data: 8'h00};
                        n = n + PIDX_W'(1);
                    end
                    open_next = 1'b0;
                    plan[n] = '{kind: OP_PUSH, data: status};
                    n = n + PIDX_W'(1);
                    if (len > 2'd1)
                    begin
                        plan[n] = '{kind: OP_PUSH, data: cmd.short_word[15:8]};
                        n = n + PIDX_W'(1);
                    end
                    if (len > 2'd2)
                    begin
                        plan[n] = '{kind: OP_PUSH, data: cmd.short_word[23:16]};
                        n = n + PIDX_W'(1);
                    end
                    plan[n] = '{kind: OP_COMMIT, data: 8'h00};
                    n = n + PIDX_W'(1);
                end
            end
            REQ_SYSEX:
            begin
                if (cmd.sysex_byte == ST_SYSEX)
                begin
                    if (open_reg)
                    begin
                        plan[n] = '{kind: OP_COMMIT, data: 8'h00};
                        n = n + PIDX_W'(1);
                    end
                    open_next = 1'b1;
                end
                if (open_next)
                begin
                    plan[n] = '{kind: OP_PUSH, data: cmd.sysex_byte};
                    n = n + PIDX_W'(1);
                    if (cmd.sysex_byte == ST_EOX)
                    begin
                        plan[n] = '{kind: OP_COMMIT, data: 8'h00};
                        n = n + PIDX_W'(1);
                        open_next = 1'b0;
                    end
                end
            end
            REQ_READ:
            begin
                plan[n] = '{kind: OP_READ, data: 8'h00};
                n = n + PIDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign q_push = busy_reg && (idx_reg != cnt_reg) && !q_full;
    assign q_op   = plan_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            open_reg <= 1'b0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                open_reg <= open_next;
                cnt_reg  <= n + PIDX_W'(1);
                idx_reg  <= '0;
            end
            else
            begin
                if (item_done)
                    busy_reg <= 1'b0;
                if (q_push)
                    idx_reg <= idx_reg + PIDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < PLAN_LEN; i++)
            begin
                plan_reg[i] <= plan[i];
            end
        end
    end

endmodule

// File: design/mmfr_opq.sv
`timescale 1ns / 1ps

module mmfr_opq import mmfr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  din,
    input  logic pop,
    output op_t  dout,
    output logic empty,
    output logic full
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_reg;
    logic [QIDX_W-1:0] rd_reg;
    logic [QIDX_W:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QIDX_W+1)'(QUEUE_DEPTH));
    assign dout  = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QIDX_W'(1);
            if (pop)
                rd_reg <= rd_reg + QIDX_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (QIDX_W+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (QIDX_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= din;
    end

endmodule

// File: design/mmfr_back.sv
`timescale 1ns / 1ps

module mmfr_back import mmfr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  op_t     op,
    input  logic    op_avail,
    output logic    pop,
    output logic    item_done,
    output logic    done,
    output result_t result
);

    typedef enum logic [1:0] {
        BK_EXEC = 2'b01,
        BK_WAIT = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;
    ptr_t        committed_reg, committed_next;
    ptr_t        pending_reg, pending_next;
    ptr_t        read_reg, read_next;
    logic        ovf_reg, ovf_next;
    logic [31:0] count_reg, count_next;
    logic        rvalid_reg, rvalid_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        drop_reg, drop_next;
    logic        done_reg, done_next;
    result_t     result_reg, result_next;

    logic        we;
    logic [7:0]  rdata;
    ptr_t        push_ptr;

    assign push_ptr = ptr_next(pending_reg);

    mmfr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (pending_reg),
        .wdata (op.data),
        .raddr (read_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        committed_next = committed_reg;
        pending_next   = pending_reg;
        read_next      = read_reg;
        ovf_next       = ovf_reg;
        count_next     = count_reg;
        rvalid_next    = rvalid_reg;
        rbyte_next     = rbyte_reg;
        drop_next      = drop_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        we             = 1'b0;
        pop            = 1'b0;
        item_done      = 1'b0;
        unique case (state_reg)
            BK_EXEC:
            begin
                if (op_avail)
                begin
                    pop = 1'b1;
                    case (op.kind)
                        OP_PUSH:
                        begin
                            if (!ovf_reg)
                            begin
                                // refuse the byte that would meet the reader
                                if (push_ptr == read_reg)
                                    ovf_next = 1'b1;
                                else
                                begin
                                    we           = 1'b1;
                                    pending_next = push_ptr;
                                    count_next   = count_reg + 32'd1;
                                end
                            end
                        end
                        OP_COMMIT:
                        begin
                            if (ovf_reg)
                            begin
                                pending_next = committed_reg;
                                ovf_next     = 1'b0;
                                drop_next    = 1'b1;
                            end
                            else
                                committed_next = pending_reg;
                        end
                        OP_READ:
                        begin
                            if (read_reg != committed_reg)
                                state_next = BK_WAIT;
                        end
                        default:
                        begin
                            item_done   = 1'b1;
                            done_next   = 1'b1;
                            result_next = '{read_valid:      rvalid_reg,
                                            read_byte:       rbyte_reg,
                                            message_dropped: drop_reg,
                                            bytes_pushed:    count_reg};
                            rvalid_next = 1'b0;
                            rbyte_next  = 8'h00;
                            drop_next   = 1'b0;
                        end
                    endcase
                end
            end
            BK_WAIT:
            begin
                rvalid_next = 1'b1;
                rbyte_next  = rdata;
                read_next   = ptr_next(read_reg);
                state_next  = BK_EXEC;
            end
            default:
            begin
                state_next = BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            committed_reg <= '0;
            pending_reg   <= '0;
            read_reg      <= '0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            rvalid_reg    <= 1'b0;
            rbyte_reg     <= 8'h00;
            drop_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            committed_reg <= committed_next;
            pending_reg   <= pending_next;
            read_reg      <= read_next;
            ovf_reg       <= ovf_next;
            count_reg     <= count_next;
            rvalid_reg    <= rvalid_next;
            rbyte_reg     <= rbyte_next;
            drop_reg      <= drop_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: design/midi_message_framing_ring_core.sv
`timescale 1ns / 1ps

// MIDI input framer with a byte ring.
// Command channel: cmd is taken at a rising edge with start high and busy
// low. req_type selects a short message, one SysEx byte or a read of one
// committed byte; busy stays high until that command's result is out.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall it, so results are never held back.
// The front decodes each command into 1 to 6 ring ops (push, commit,
// read, finish) and feeds them through a 4-deep op queue to the back,
// which executes one op per cycle while the queue holds one, against a
// single ring RAM with a registered read port; a read that returns a
// byte holds the back in a wait state for the RAM read.
// busy falls with done, so the next command can be taken then; a new
// command is not taken while the last one is still in flight.
// Reset clears all pointers, the overflow flag, the SysEx framing state
// and the byte count; the ring contents are not cleared.
module midi_message_framing_ring_core import mmfr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    op_t  q_in;
    op_t  q_head;
    logic item_done;

    mmfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .item_done (item_done),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_in)
    );

    mmfr_opq u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    mmfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (q_head),
        .op_avail  (!q_empty),
        .pop       (q_pop),
        .item_done (item_done),
        .done      (done),
        .result    (result)
    );

endmodule
